// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  localparam int HUE_W = 15;
  localparam int CH_W  = 8;
  localparam int HW_W  = 15;
  localparam int REM_W = 12;
  localparam int K_W   = 16;
  localparam int N_W   = 24;

  localparam int HUE_CIRCLE = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int FULL16     = 65280;
  localparam int HALF16     = 32640;
  localparam int HALF8      = 127;

  // floor(x / 15) for x below 3840 as (x * 4370) >> 16
  localparam logic [12:0] DIV15_RECIP  = 13'd4370;
  // floor(x / 255) for x below 65280 as (x * 32897) >> 23
  localparam logic [30:0] DIV255_RECIP = 31'd32897;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    grey;
  } mix_ctl_t;

  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [30:0] pr;
    pr = {15'd0, x} * DIV255_RECIP;
    return pr[30:23];
  endfunction

endpackage

// ===== rtl/hsv2rgb_if.sv =====
interface hsv_word_if import hsv2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_word_if import hsv2rgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsv2rgb_swizzle.sv =====
module hsv2rgb_swizzle import hsv2rgb_pkg::*; (
  input  mix_ctl_t        ctl,
  input  logic [CH_W-1:0] v,
  input  logic [CH_W-1:0] p,
  input  logic [CH_W-1:0] q,
  input  logic [CH_W-1:0] t,
  output logic [CH_W-1:0] red,
  output logic [CH_W-1:0] green,
  output logic [CH_W-1:0] blue
);

  always_comb begin
    if (ctl.grey) begin
      red   = v;
      green = v;
      blue  = v;
    end else begin
      unique case (ctl.sector)
        SEC_RY: begin red = v; green = t; blue = p; end
        SEC_YG: begin red = q; green = v; blue = p; end
        SEC_GC: begin red = p; green = v; blue = t; end
        SEC_CB: begin red = p; green = q; blue = v; end
        SEC_BM: begin red = t; green = p; blue = v; end
        default: begin red = v; green = p; blue = q; end
      endcase
    end
  end

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter. One pixel word is taken on hsv and one RGB
// word leaves on rgb for it. Six register stages: hue wrap and sector,
// fraction and p, saturation products, value products, q/t rounding, then
// the channel select into the output register; the last stage's valid
// flag is rgb.valid. Throughput is one pixel per clock, with each stage
// holding its word under back-pressure and taking a new one as soon as
// its successor moves on. Zero saturation gives grey (all channels equal
// to brightness); hue codes at or above 360 degrees wrap round the circle.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  hsv_word_if.sink   hsv,
  rgb_word_if.source rgb
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // stage enables ripple back from the output
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || rgb.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign hsv.ready = en[0];
  assign rgb.valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsv.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: wrap, sector, remainder, v*(255-s)
  logic [HUE_W-1:0] hue_w;
  logic [HW_W-1:0]  hw;
  logic [HW_W-1:0]  base;
  sector_t          sec_c;
  mix_ctl_t         ctl1;
  logic [REM_W-1:0] rem1;
  logic [CH_W-1:0]  s1;
  logic [CH_W-1:0]  v1;
  logic [15:0]      pn1;

  always_comb begin
    hue_w = (hsv.hue >= HUE_W'(HUE_CIRCLE)) ? hsv.hue - HUE_W'(HUE_CIRCLE) : hsv.hue;
    hw    = hue_w[HW_W-1:0];
    priority if (hw >= HW_W'(5 * HUE_SECTOR)) begin
      sec_c = SEC_MR; base = HW_W'(5 * HUE_SECTOR);
    end else if (hw >= HW_W'(4 * HUE_SECTOR)) begin
      sec_c = SEC_BM; base = HW_W'(4 * HUE_SECTOR);
    end else if (hw >= HW_W'(3 * HUE_SECTOR)) begin
      sec_c = SEC_CB; base = HW_W'(3 * HUE_SECTOR);
    end else if (hw >= HW_W'(2 * HUE_SECTOR)) begin
      sec_c = SEC_GC; base = HW_W'(2 * HUE_SECTOR);
    end else if (hw >= HW_W'(HUE_SECTOR)) begin
      sec_c = SEC_YG; base = HW_W'(HUE_SECTOR);
    end else begin
      sec_c = SEC_RY; base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      logic [HW_W-1:0] rem_full;
      rem_full    = hw - base;
      ctl1.sector <= sec_c;
      ctl1.grey   <= (hsv.saturation == '0);
      rem1        <= rem_full[REM_W-1:0];
      s1          <= hsv.saturation;
      v1          <= hsv.brightness;
      pn1         <= {8'd0, hsv.brightness} * {8'd0, 8'd255 - hsv.saturation};
    end
  end

  // stage 2: f8 = rem / 15, p = round(pn / 255)
  mix_ctl_t        ctl2;
  logic [CH_W-1:0] f8_2;
  logic [CH_W-1:0] s2;
  logic [CH_W-1:0] v2;
  logic [CH_W-1:0] p2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      logic [24:0] fr;
      fr   = {13'd0, rem1} * {12'd0, DIV15_RECIP};
      ctl2 <= ctl1;
      f8_2 <= fr[23:16];
      s2   <= s1;
      v2   <= v1;
      p2   <= div255(pn1 + 16'(HALF8));
    end
  end

  // stage 3: saturation products
  mix_ctl_t        ctl3;
  logic [CH_W-1:0] v3;
  logic [CH_W-1:0] p3;
  logic [K_W-1:0]  kq3;
  logic [K_W-1:0]  kt3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      logic [16:0] sf;
      logic [16:0] sg;
      sf   = {9'd0, s2} * {9'd0, f8_2};
      sg   = {9'd0, s2} * {8'd0, 9'd256 - {1'b0, f8_2}};
      ctl3 <= ctl2;
      v3   <= v2;
      p3   <= p2;
      kq3  <= K_W'(FULL16) - sf[K_W-1:0];
      kt3  <= K_W'(FULL16) - sg[K_W-1:0];
    end
  end

  // stage 4: value products
  mix_ctl_t        ctl4;
  logic [CH_W-1:0] v4;
  logic [CH_W-1:0] p4;
  logic [N_W-1:0]  nq4;
  logic [N_W-1:0]  nt4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ctl4 <= ctl3;
      v4   <= v3;
      p4   <= p3;
      nq4  <= {16'd0, v3} * {8'd0, kq3};
      nt4  <= {16'd0, v3} * {8'd0, kt3};
    end
  end

  // stage 5: round by 65280 as >> 8 then / 255
  mix_ctl_t        ctl5;
  logic [CH_W-1:0] v5;
  logic [CH_W-1:0] p5;
  logic [CH_W-1:0] q5;
  logic [CH_W-1:0] t5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      logic [N_W-1:0] mq;
      logic [N_W-1:0] mt;
      mq   = nq4 + N_W'(HALF16);
      mt   = nt4 + N_W'(HALF16);
      ctl5 <= ctl4;
      v5   <= v4;
      p5   <= p4;
      q5   <= div255(mq[23:8]);
      t5   <= div255(mt[23:8]);
    end
  end

  // stage 6: channel order and output register
  logic [CH_W-1:0] red_c;
  logic [CH_W-1:0] green_c;
  logic [CH_W-1:0] blue_c;

  hsv2rgb_swizzle u_swizzle (
    .ctl   (ctl5),
    .v     (v5),
    .p     (p5),
    .q     (q5),
    .t     (t5),
    .red   (red_c),
    .green (green_c),
    .blue  (blue_c)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rgb.red   <= red_c;
      rgb.green <= green_c;
      rgb.blue  <= blue_c;
    end
  end

`ifndef ASSERT_OFF
  a_rem_in_sector: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (rem1 < REM_W'(HUE_SECTOR)))
    else $error("hue remainder outside sector");

  a_grey_out: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && en[5] && ctl5.grey) |=>
      (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("grey word with unequal channels");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !hsv.ready |-> (rgb.valid && !rgb.ready))
    else $error("input stalled without output back-pressure");
`endif

endmodule
